// ----- design/lbod_pkg.sv -----
// Shared types, constants and tables of the lidar box obstacle detector.
`timescale 1ns / 1ps

package lbod_pkg;

   // Field widths
   localparam int RANGE_W      = 16;
   localparam int ANGLE_W      = 16;
   localparam int HALF_WIDTH_W = 12;
   localparam int DEPTH_W      = 14;
   localparam int HIT_OUT_W    = 12;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   // Default parameter values
   localparam int CORDIC_STAGES_DEF  = 16;
   localparam int HIT_COUNT_BITS_DEF = 12;

   // CORDIC datapath: Q16 millimetres with growth headroom, residual angle 2^32 per turn
   localparam int DATA_W = 35;
   localparam int ZW     = 33;
   localparam int FRAC_W = 16;

   // Range scale factor, inverse CORDIC gain in Q16
   localparam logic signed [RANGE_W:0] GAIN_Q16 = 17'sd39797;

   // Entries of the point queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register reset values
   localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RST = 12'd350;
   localparam logic [DEPTH_W-1:0]      DEPTH_RST      = 14'd1500;
   localparam logic [ANGLE_W-1:0]      START_RST      = 16'd0;
   localparam logic [ANGLE_W-1:0]      STEP_RST       = 16'd182;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_HALF_WIDTH  = 2'd0,
      REG_BOX_DEPTH   = 2'd1,
      REG_START_ANGLE = 2'd2,
      REG_ANGLE_STEP  = 2'd3
   } csr_index_type;

   // Angle sequencing settings used by the front
   typedef struct packed {
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] angle_step;
   } angle_cfg_type;

   // Box limits used by the back
   typedef struct packed {
      logic [HALF_WIDTH_W-1:0] half_width_mm;
      logic [DEPTH_W-1:0]      box_depth_mm;
   } box_cfg_type;

   // One queued point: range, absolute beam angle, scan end mark
   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic [ANGLE_W-1:0] angle;
      logic               last;
   } point_type;

   // Rotation state carried down the CORDIC pipe
   typedef struct packed {
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] s;
      logic signed [ZW-1:0]     z;
      logic                     last;
   } cordic_state_type;

   // arctan(2^-i) with a full turn equal to 2^32
   function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return $signed(ZW'(val));
   endfunction

endpackage

// ----- design/lbod_front.sv -----
// Front end: accepts points, tracks the scan angle and queues tagged points.
`timescale 1ns / 1ps

module lbod_front (
   input  logic                              clock,
   input  logic                              reset,
   input  lbod_pkg::angle_cfg_type           angle_cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lbod_pkg::RANGE_W-1:0]      req_range_mm,
   input  logic                              req_end_of_scan,
   input  logic                              queue_full,
   output logic                              queue_push,
   output lbod_pkg::point_type               queue_data
);

   logic [lbod_pkg::ANGLE_W-1:0] offset_ff;
   logic [lbod_pkg::ANGLE_W-1:0] offset_in;
   logic                         accept;

   // Take a beat whenever the queue has room
   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign queue_push = accept;

   // Absolute beam angle, wraps mod a full turn
   always_comb begin
      queue_data.range_mm = req_range_mm;
      queue_data.angle    = angle_cfg.start_angle + offset_ff;
      queue_data.last     = req_end_of_scan;
   end

   // Offset advances per point and restarts after the last point of a scan
   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         if (req_end_of_scan) begin
            offset_in = '0;
         end else begin
            offset_in = offset_ff + angle_cfg.angle_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   a_offset_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_scan) |=> (offset_ff == '0))
      else $error("angle offset not cleared after scan end");

endmodule

// ----- design/lbod_queue.sv -----
// Short point queue that decouples the front from the CORDIC back end.
`timescale 1ns / 1ps

module lbod_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lbod_pkg::point_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output lbod_pkg::point_type pop_data
);

   localparam int PtrW = $clog2(lbod_pkg::QUEUE_DEPTH);

   lbod_pkg::point_type mem_ff [lbod_pkg::QUEUE_DEPTH];
   logic [PtrW:0]       wr_ptr_ff;
   logic [PtrW:0]       wr_ptr_in;
   logic [PtrW:0]       rd_ptr_ff;
   logic [PtrW:0]       rd_ptr_in;

   // Extra pointer bit tells full from empty
   assign full      = (wr_ptr_ff[PtrW] != rd_ptr_ff[PtrW]) &&
                      (wr_ptr_ff[PtrW-1:0] == rd_ptr_ff[PtrW-1:0]);
   assign not_empty = (wr_ptr_ff != rd_ptr_ff);
   assign pop_data  = mem_ff[rd_ptr_ff[PtrW-1:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[PtrW-1:0]] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full point queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty point queue");

endmodule

// ----- design/lbod_cordic_stage.sv -----
// One registered CORDIC rotation stage.
`timescale 1ns / 1ps

module lbod_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  lbod_pkg::cordic_state_type in_state,
   output logic                       out_valid,
   output lbod_pkg::cordic_state_type out_state
);

   localparam logic signed [lbod_pkg::ZW-1:0] Atan = lbod_pkg::atan_entry(STAGE);

   logic                       valid_ff;
   lbod_pkg::cordic_state_type state_ff;
   lbod_pkg::cordic_state_type state_in;
   logic signed [lbod_pkg::DATA_W-1:0] dc;
   logic signed [lbod_pkg::DATA_W-1:0] ds;

   // Shifts round toward minus infinity; zero residual rotates positive
   always_comb begin
      dc            = in_state.s >>> STAGE;
      ds            = in_state.c >>> STAGE;
      state_in.last = in_state.last;
      if (!in_state.z[lbod_pkg::ZW-1]) begin
         state_in.c = in_state.c - dc;
         state_in.s = in_state.s + ds;
         state_in.z = in_state.z - Atan;
      end else begin
         state_in.c = in_state.c + dc;
         state_in.s = in_state.s - ds;
         state_in.z = in_state.z + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ----- design/lbod_back.sv -----
// Back end: range scaling, CORDIC pipe, box test, hit counter and result register.
`timescale 1ns / 1ps

module lbod_back #(
   parameter int CORDIC_STAGES  = lbod_pkg::CORDIC_STAGES_DEF,
   parameter int HIT_COUNT_BITS = lbod_pkg::HIT_COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lbod_pkg::box_cfg_type             box_cfg,
   input  logic                              item_valid,
   input  lbod_pkg::point_type               item,
   output logic                              item_pop,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_path_clear,
   output logic [lbod_pkg::HIT_OUT_W-1:0]    rsp_hit_count
);

   localparam int DataW = lbod_pkg::DATA_W;
   localparam int ZW    = lbod_pkg::ZW;
   localparam int OutW  = lbod_pkg::HIT_OUT_W;
   localparam int RngW  = lbod_pkg::RANGE_W;
   localparam int AngW  = lbod_pkg::ANGLE_W;
   localparam int FracW = lbod_pkg::FRAC_W;
   localparam logic [HIT_COUNT_BITS-1:0] HitMax = {HIT_COUNT_BITS{1'b1}};

   logic advance;

   // Whole pipe moves unless a finished result is still waiting
   assign advance  = !rsp_valid || rsp_ready;
   assign item_pop = advance && item_valid;

   // Entry stage: half-turn fold and range times gain
   logic                          flip;
   logic signed [RngW:0]          range_sgn;
   logic signed [2*RngW+1:0]      prod;
   logic [AngW-1:0]               angle_fold;
   lbod_pkg::cordic_state_type    entry_in;

   logic                          stage_valid [CORDIC_STAGES+1];
   lbod_pkg::cordic_state_type    stage_state [CORDIC_STAGES+1];
   logic                          entry_valid_ff;
   lbod_pkg::cordic_state_type    entry_ff;

   always_comb begin
      flip       = item.angle[AngW-1] ^ item.angle[AngW-2];
      range_sgn  = flip ? -$signed({1'b0, item.range_mm}) : $signed({1'b0, item.range_mm});
      angle_fold = flip ? item.angle + {1'b1, {(AngW-1){1'b0}}} : item.angle;
      prod       = range_sgn * lbod_pkg::GAIN_Q16;
      entry_in.c    = DataW'(prod);
      entry_in.s    = '0;
      entry_in.z    = ZW'($signed({angle_fold, {FracW{1'b0}}}));
      entry_in.last = item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_state[0] = entry_ff;

   // Rotation stages
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      lbod_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_state  (stage_state[i]),
         .out_valid (stage_valid[i+1]),
         .out_state (stage_state[i+1])
      );
   end

   // Box test: |x| <= half width, -depth <= y < 0, all in Q16
   lbod_pkg::cordic_state_type fin;
   logic signed [DataW-1:0]    lim_x;
   logic signed [DataW-1:0]    lim_y;
   logic                       in_box_in;
   logic                       cmp_valid_ff;
   logic                       cmp_hit_ff;
   logic                       cmp_last_ff;

   always_comb begin
      fin       = stage_state[CORDIC_STAGES];
      lim_x     = $signed(DataW'({box_cfg.half_width_mm, {FracW{1'b0}}}));
      lim_y     = $signed(DataW'({box_cfg.box_depth_mm, {FracW{1'b0}}}));
      in_box_in = (fin.s >= -lim_x) && (fin.s <= lim_x) &&
                  (fin.c >= -lim_y) && fin.c[DataW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else if (advance) begin
         cmp_valid_ff <= stage_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmp_hit_ff  <= in_box_in;
         cmp_last_ff <= fin.last;
      end
   end

   // Saturating hit counter and result register
   logic [HIT_COUNT_BITS-1:0] hits_ff;
   logic [HIT_COUNT_BITS-1:0] hits_in;
   logic [HIT_COUNT_BITS-1:0] hits_next;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_path_clear_ff;
   logic [OutW-1:0]           rsp_hit_count_ff;

   always_comb begin
      hits_next = (cmp_hit_ff && hits_ff != HitMax) ? hits_ff + 1'b1 : hits_ff;
      hits_in   = hits_ff;
      if (advance && cmp_valid_ff) begin
         hits_in = cmp_last_ff ? '0 : hits_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = cmp_valid_ff && cmp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmp_valid_ff && cmp_last_ff) begin
         rsp_path_clear_ff <= (hits_next == '0);
         rsp_hit_count_ff  <= OutW'(hits_next);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_clear = rsp_path_clear_ff;
   assign rsp_hit_count  = rsp_hit_count_ff;

   a_hits_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && cmp_valid_ff && cmp_last_ff) |=> (hits_ff == '0))
      else $error("hit counter not cleared after scan end");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(cmp_valid_ff) && $stable(entry_valid_ff)))
      else $error("pipe moved while result stalled");

endmodule

// ----- design/lidar_box_obstacle_detector_unit.sv -----
// Top level of the lidar box obstacle detector: registers, front, queue and back.
`timescale 1ns / 1ps

// Usage:
//  req_ channel: one lidar point per beat (range in mm, end_of_scan on the last
//  point of a scan). Beam angle is start_angle plus the point index times
//  angle_step. rsp_ channel: one beat per scan, carrying the hit count of points
//  with |x| <= half_width_mm and -box_depth_mm <= y < 0, and path_clear when
//  that count is zero. csr_ port writes a register; write only
//  while no scan is in flight.
//  Throughput: one point per cycle while no result waits for rsp_ready, set by
//  the fully pipelined CORDIC (one registered stage per iteration) behind a
//  four-entry point queue. A scan-end beat passes the queue, the entry register,
//  the CORDIC stages and the compare and result registers before rsp_valid.
//  Reset: registers take their defaults, angle offset and hit counter clear,
//  the queue and pipe empty; no clearing pass.
//  Stall: while a result waits for rsp_ready the pipe holds, the queue fills,
//  and req_ready drops once it is full.

module lidar_box_obstacle_detector_unit #(
   parameter int CORDIC_STAGES  = lbod_pkg::CORDIC_STAGES_DEF,
   parameter int HIT_COUNT_BITS = lbod_pkg::HIT_COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lbod_pkg::RANGE_W-1:0]        req_range_mm,
   input  logic                                req_end_of_scan,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_path_clear,
   output logic [lbod_pkg::HIT_OUT_W-1:0]      rsp_hit_count,
   input  logic                                csr_we,
   input  logic [lbod_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbod_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lbod_pkg::angle_cfg_type angle_cfg_ff;
   lbod_pkg::angle_cfg_type angle_cfg_in;
   lbod_pkg::box_cfg_type   box_cfg_ff;
   lbod_pkg::box_cfg_type   box_cfg_in;

   // Register write decode
   always_comb begin
      angle_cfg_in = angle_cfg_ff;
      box_cfg_in   = box_cfg_ff;
      if (csr_we) begin
         case (lbod_pkg::csr_index_type'(csr_index))
            lbod_pkg::REG_HALF_WIDTH:
               box_cfg_in.half_width_mm = csr_wdata[lbod_pkg::HALF_WIDTH_W-1:0];
            lbod_pkg::REG_BOX_DEPTH:
               box_cfg_in.box_depth_mm = csr_wdata[lbod_pkg::DEPTH_W-1:0];
            lbod_pkg::REG_START_ANGLE:
               angle_cfg_in.start_angle = csr_wdata[lbod_pkg::ANGLE_W-1:0];
            lbod_pkg::REG_ANGLE_STEP:
               angle_cfg_in.angle_step = csr_wdata[lbod_pkg::ANGLE_W-1:0];
            default: begin
               angle_cfg_in = angle_cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_cfg_ff.half_width_mm <= lbod_pkg::HALF_WIDTH_RST;
         box_cfg_ff.box_depth_mm  <= lbod_pkg::DEPTH_RST;
         angle_cfg_ff.start_angle <= lbod_pkg::START_RST;
         angle_cfg_ff.angle_step  <= lbod_pkg::STEP_RST;
      end else begin
         box_cfg_ff   <= box_cfg_in;
         angle_cfg_ff <= angle_cfg_in;
      end
   end

   // Front to queue to back
   logic                queue_full;
   logic                queue_push;
   lbod_pkg::point_type queue_wdata;
   logic                queue_pop;
   logic                queue_not_empty;
   lbod_pkg::point_type queue_rdata;

   lbod_front u_front (
      .clock           (clock),
      .reset           (reset),
      .angle_cfg       (angle_cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_range_mm    (req_range_mm),
      .req_end_of_scan (req_end_of_scan),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_data      (queue_wdata)
   );

   lbod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_wdata),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_rdata)
   );

   lbod_back #(
      .CORDIC_STAGES  (CORDIC_STAGES),
      .HIT_COUNT_BITS (HIT_COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .box_cfg        (box_cfg_ff),
      .item_valid     (queue_not_empty),
      .item           (queue_rdata),
      .item_pop       (queue_pop),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_path_clear (rsp_path_clear),
      .rsp_hit_count  (rsp_hit_count)
   );

endmodule
